// ===== src/acc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package acc_pkg;
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_EXEC = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_NUM = 3'd1;
    localparam logic [2:0] EV_CHAR = 3'd2;
    localparam logic [2:0] EV_HALT = 3'd3;
    localparam logic [2:0] EV_STACK = 3'd4;

    localparam logic [3:0] OP_HLT = 4'h0;
    localparam logic [3:0] OP_LDA = 4'h1;
    localparam logic [3:0] OP_STA = 4'h2;
    localparam logic [3:0] OP_ADD = 4'h3;
    localparam logic [3:0] OP_SUB = 4'h4;
    localparam logic [3:0] OP_JMP = 4'h5;
    localparam logic [3:0] OP_CAL = 4'h6;
    localparam logic [3:0] OP_MUL = 4'h7;
    localparam logic [3:0] OP_SYS = 4'h8;
    localparam logic [3:0] OP_BRZ = 4'h9;
    localparam logic [3:0] OP_BRN = 4'hA;
    localparam logic [3:0] OP_PRT = 4'hB;
    localparam logic [3:0] OP_PRC = 4'hC;

    localparam logic [11:0] SYS_IAC = 12'h002;
    localparam logic [11:0] SYS_RET = 12'h005;

    typedef struct packed {
        logic [1:0] func;
        logic [11:0] address;
        logic [15:0] data;
    } cmd_t;
endpackage
`default_nettype wire

// ===== src/acc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acc_front (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire acc_pkg::cmd_t in_cmd,
    output logic q_valid,
    input wire logic q_pop,
    output acc_pkg::cmd_t q_cmd
);
    import acc_pkg::*;

    cmd_t q_mem [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = q_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (q_pop && q_valid) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

`ifndef ASSERT_OFF
    a_noover: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !q_pop) |=> cnt_reg == 2'd2) else $error("lost item");
`endif
endmodule
`default_nettype wire

// ===== src/acc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module acc_back #(
    parameter int MEM_BYTES = 4096,
    parameter int STACK_BYTES = 256
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic q_valid,
    output logic q_pop,
    input wire acc_pkg::cmd_t q_cmd,
    input wire logic [11:0] start_address,
    output logic out_valid,
    input wire logic out_stall,
    output logic [2:0] event_res,
    output logic signed [15:0] print_value,
    output logic [11:0] program_counter,
    output logic [15:0] accumulator,
    output logic halted
);
    import acc_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_W0, S_F0, S_F1, S_F2, S_O0, S_O1, S_EX, S_MUL, S_DONE
    } st_t;

    st_t st_reg;
    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rd_reg;
    logic [AW-1:0] ma;
    logic [7:0] mwd;
    logic mwe;
    logic [AW-1:0] clr_reg;

    cmd_t cmd_reg;
    logic [11:0] pc_reg;
    logic [15:0] acc_reg, ir_reg, op_reg, stw_reg;
    logic [7:0] hi_reg;
    logic neg_reg, zero_reg, halt_reg;
    logic [8:0] sp_reg;
    logic [29:0] prod_reg;
    logic [2:0] ev_reg;
    logic [15:0] pv_reg;
    logic ov_reg;

    logic [3:0] opc;
    logic [11:0] opa;
    logic [11:0] pc_nx;
    logic is_ret;
    assign opc = ir_reg[15:12];
    assign opa = ir_reg[11:0];
    assign pc_nx = pc_reg + 12'd2;
    assign is_ret = (opc == OP_SYS) && (opa == SYS_RET);

    always_ff @(posedge clk)
    begin
        if (mwe) mem[ma] <= mwd;
        rd_reg <= mem[ma];
    end

    function automatic logic [15:0] sm_add(input logic [15:0] x, input logic [15:0] y);
        logic signed [16:0] xi, yi, s;
        logic [16:0] m;
        begin
            xi = x[15] ? -$signed({2'b0, x[14:0]}) : $signed({2'b0, x[14:0]});
            yi = y[15] ? -$signed({2'b0, y[14:0]}) : $signed({2'b0, y[14:0]});
            s = xi + yi;
            m = s[16] ? 17'(-s) : 17'(s);
            sm_add = {s[16], m[14:0]};
        end
    endfunction

    logic ret_err, cal_err;
    assign cal_err = (10'(sp_reg) + 10'd2) > 10'(STACK_BYTES);
    assign ret_err = sp_reg < 9'd2;

    always_comb
    begin
        ma = '0;
        mwd = '0;
        mwe = 1'b0;
        case (st_reg)
            S_CLR:
            begin
                ma = clr_reg;
                mwe = 1'b1;
            end
            S_IDLE:
            begin
                ma = AW'(q_cmd.address);
                if (q_valid && q_cmd.func == FUNC_WRITE)
                begin
                    mwe = 1'b1;
                    mwd = q_cmd.data[15:8];
                end
                else ma = AW'(pc_reg);
            end
            S_W0:
            begin
                ma = AW'(cmd_reg.address + 12'd1);
                mwe = 1'b1;
                mwd = cmd_reg.data[7:0];
            end
            S_F0: ma = AW'(pc_reg + 12'd1);
            S_F2:
            begin
                if (opc == OP_STA)
                begin
                    ma = AW'(opa);
                    mwe = 1'b1;
                    mwd = acc_reg[15:8];
                end
                else if (opc == OP_CAL)
                begin
                    ma = AW'(sp_reg);
                    mwe = !cal_err;
                    mwd = {4'h0, pc_nx[11:8]};
                end
                else if (is_ret) ma = AW'(sp_reg - 9'd2);
                else ma = AW'(opa);
            end
            S_O0:
            begin
                if (opc == OP_STA)
                begin
                    ma = AW'(opa + 12'd1);
                    mwe = 1'b1;
                    mwd = acc_reg[7:0];
                end
                else if (opc == OP_CAL)
                begin
                    ma = AW'(sp_reg + 9'd1);
                    mwe = !cal_err;
                    mwd = pc_nx[7:0];
                end
                else if (is_ret) ma = AW'(sp_reg - 9'd1);
                else ma = AW'(opa + 12'd1);
            end
            default: ;
        endcase
    end

    assign q_pop = (st_reg == S_IDLE) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR;
            clr_reg <= '0;
            pc_reg <= '0;
            acc_reg <= '0;
            neg_reg <= 1'b0;
            zero_reg <= 1'b0;
            halt_reg <= 1'b0;
            sp_reg <= '0;
            ov_reg <= 1'b0;
            ev_reg <= EV_NONE;
            pv_reg <= '0;
        end
        else
        begin
            if (st_reg == S_DONE && (!ov_reg || !out_stall)) ov_reg <= 1'b1;
            else if (ov_reg && !out_stall) ov_reg <= 1'b0;
            case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(MEM_BYTES - 1)) st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_cmd;
                        ev_reg <= EV_NONE;
                        pv_reg <= '0;
                        if (q_cmd.func == FUNC_WRITE) st_reg <= S_W0;
                        else if (q_cmd.func == FUNC_EXEC && !halt_reg) st_reg <= S_F0;
                        else
                        begin
                            if (q_cmd.func == FUNC_RESTART)
                            begin
                                pc_reg <= start_address;
                                halt_reg <= 1'b0;
                                neg_reg <= 1'b0;
                                zero_reg <= 1'b0;
                            end
                            st_reg <= S_DONE;
                        end
                    end
                end
                S_W0: st_reg <= S_DONE;
                S_F0:
                begin
                    hi_reg <= rd_reg;
                    st_reg <= S_F1;
                end
                S_F1:
                begin
                    ir_reg <= {hi_reg, rd_reg};
                    st_reg <= S_F2;
                end
                S_F2: st_reg <= S_O0;
                S_O0:
                begin
                    hi_reg <= rd_reg;
                    pc_reg <= pc_nx;
                    st_reg <= S_O1;
                end
                S_O1:
                begin
                    op_reg <= {hi_reg, rd_reg};
                    prod_reg <= acc_reg[14:0] * {hi_reg[6:0], rd_reg};
                    st_reg <= S_EX;
                end
                S_EX:
                begin
                    st_reg <= S_DONE;
                    case (opc)
                        OP_HLT:
                        begin
                            halt_reg <= 1'b1;
                            ev_reg <= EV_HALT;
                        end
                        OP_LDA: stw_reg <= op_reg;
                        OP_ADD: stw_reg <= sm_add(acc_reg, op_reg);
                        OP_SUB: stw_reg <= sm_add(acc_reg, op_reg ^ 16'h8000);
                        OP_MUL: stw_reg <= 16'h0;
                        OP_JMP: pc_reg <= opa;
                        OP_CAL:
                        begin
                            if (cal_err)
                            begin
                                halt_reg <= 1'b1;
                                ev_reg <= EV_STACK;
                            end
                            else
                            begin
                                sp_reg <= sp_reg + 9'd2;
                                pc_reg <= opa;
                            end
                        end
                        OP_SYS:
                        begin
                            if (opa == SYS_RET)
                            begin
                                if (ret_err)
                                begin
                                    halt_reg <= 1'b1;
                                    ev_reg <= EV_STACK;
                                end
                                else
                                begin
                                    sp_reg <= sp_reg - 9'd2;
                                    pc_reg <= {op_reg[11:0]};
                                end
                            end
                            else if (opa == SYS_IAC) acc_reg <= sm_add(acc_reg, 16'h0001);
                            else
                            begin
                                halt_reg <= 1'b1;
                                ev_reg <= EV_HALT;
                            end
                        end
                        OP_BRZ: if (zero_reg) pc_reg <= opa;
                        OP_BRN: if (neg_reg) pc_reg <= opa;
                        OP_PRT:
                        begin
                            ev_reg <= EV_NUM;
                            pv_reg <= op_reg[15] ? 16'(-{1'b0, op_reg[14:0]})
                                                 : {1'b0, op_reg[14:0]};
                        end
                        OP_PRC:
                        begin
                            ev_reg <= EV_CHAR;
                            pv_reg <= {8'h0, opa[7:0]};
                        end
                        default: ;
                    endcase
                    if (opc == OP_LDA || opc == OP_ADD || opc == OP_SUB || opc == OP_MUL)
                        st_reg <= S_MUL;
                end
                S_MUL:
                begin
                    logic [15:0] v;
                    v = (opc == OP_MUL)
                        ? {((acc_reg[15] ^ op_reg[15]) && prod_reg != 30'd0),
                           prod_reg[14:0]}
                        : stw_reg;
                    acc_reg <= v;
                    neg_reg <= v > 16'h8000;
                    zero_reg <= v == 16'h0;
                    st_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        event_res <= ev_reg;
                        print_value <= pv_reg;
                        program_counter <= pc_reg;
                        accumulator <= acc_reg;
                        halted <= halt_reg;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;

`ifndef ASSERT_OFF
    a_sp: assert property (@(posedge clk) disable iff (!rst_n)
        10'(sp_reg) <= 10'(STACK_BYTES)) else $error("stack pointer out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_popidle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == S_IDLE) else $error("pop while busy");
`endif
endmodule
`default_nettype wire

// ===== src/accumulator_cpu_core_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Handshake              | Payload
// in      | in_valid / in_stall    | func, address, data
// out     | out_valid / out_stall  | event_res, print_value, program_counter,
//         |                        | accumulator, halted
// cfg     | APB psel/penable       | start_address at 0
// A memory write runs S_IDLE, S_W0, S_DONE; a restart or an ignored beat S_IDLE, S_DONE; an
// instruction S_IDLE, S_F0-S_F2, S_O0, S_O1, S_EX, S_MUL if it sets acc and flags, S_DONE.
// A two-entry queue lets input beats be taken while the core executes.
// Reset is asynchronous; then the memory, which has a single byte port, is cleared one
// byte a cycle (MEM_BYTES, 4096 by default) before the first beat is executed.
// A stalled result holds in the output register while the next beat proceeds.
module accumulator_cpu_core_top #(
    parameter int MEM_BYTES = 4096,
    parameter int STACK_BYTES = 256
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire logic [1:0] func,
    input wire logic [11:0] address,
    input wire logic [15:0] data,
    output logic out_valid,
    input wire logic out_stall,
    output logic [2:0] event_res,
    output logic signed [15:0] print_value,
    output logic [11:0] program_counter,
    output logic [15:0] accumulator,
    output logic halted,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [1:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import acc_pkg::*;

    logic [11:0] start_reg;
    cmd_t in_cmd, q_cmd;
    logic q_valid, q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {20'h0, start_reg} : 32'h0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) start_reg <= '0;
        else if (psel && penable && pwrite && paddr == 2'd0) start_reg <= pwdata[11:0];
    end

    assign in_cmd = '{func: func, address: address, data: data};

    acc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    acc_back #(.MEM_BYTES(MEM_BYTES), .STACK_BYTES(STACK_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .start_address(start_reg), .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .print_value(print_value),
        .program_counter(program_counter), .accumulator(accumulator), .halted(halted)
    );
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import acc_pkg::*;

    typedef struct packed {
        logic [2:0] ev;
        logic [15:0] pv;
        logic [11:0] pc;
        logic [15:0] acc;
        logic hlt;
    } step_res_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic [1:0] func;
        logic [11:0] addr;
        logic [15:0] data;
        bit typed;
        step_res_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = FUNC_WRITE;
    logic [11:0] address = '0;
    logic [15:0] data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] event_res;
    logic signed [15:0] print_value;
    logic [11:0] program_counter;
    logic [15:0] accumulator;
    logic halted;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    accumulator_cpu_core_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .address(address), .data(data),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .print_value(print_value),
        .program_counter(program_counter), .accumulator(accumulator), .halted(halted),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [7:0] cpu_mem [4096];
    logic [11:0] cpu_pc;
    logic [15:0] cpu_acc;
    logic cpu_neg;
    logic cpu_zero;
    logic [8:0] cpu_sp;
    logic cpu_halt;
    logic [11:0] cpu_start;

    step_res_t pending_res[$];
    stim_row_t rows[$];
    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int n_prints = 0;
    int n_halts = 0;
    bit idle_on = 1'b1;
    int stall_left = 0;

    function automatic logic [15:0] mem_word(logic [11:0] a);
        logic [11:0] b;
        b = a + 12'd1;
        return {cpu_mem[a], cpu_mem[b]};
    endfunction

    function automatic void mem_store(logic [11:0] a, logic [15:0] v);
        logic [11:0] b;
        b = a + 12'd1;
        cpu_mem[a] = v[15:8];
        cpu_mem[b] = v[7:0];
    endfunction

    function automatic int sm_value(logic [15:0] w);
        int m;
        m = int'(w[14:0]);
        return w[15] ? -m : m;
    endfunction

    function automatic logic [15:0] sm_word(int v);
        int m;
        m = (v < 0) ? -v : v;
        return {v < 0, m[14:0]};
    endfunction

    function automatic void update_flags();
        cpu_neg = cpu_acc > 16'h8000;
        cpu_zero = cpu_acc == 16'h0000;
    endfunction

    function automatic step_res_t cpu_step(logic [1:0] f, logic [11:0] a_in, logic [15:0] d);
        step_res_t r;
        logic [15:0] ir;
        logic [3:0] op;
        logic [11:0] a;
        int pv;
        r.ev = EV_NONE;
        r.pv = '0;
        if (f == FUNC_WRITE)
            mem_store(a_in, d);
        else if (f == FUNC_RESTART)
        begin
            cpu_pc = cpu_start;
            cpu_halt = 1'b0;
            cpu_neg = 1'b0;
            cpu_zero = 1'b0;
        end
        else if (f == FUNC_EXEC && !cpu_halt)
        begin
            ir = mem_word(cpu_pc);
            op = ir[15:12];
            a = ir[11:0];
            cpu_pc = cpu_pc + 12'd2;
            case (op)
                OP_HLT:
                begin
                    cpu_halt = 1'b1;
                    r.ev = EV_HALT;
                end
                OP_LDA:
                begin
                    cpu_acc = mem_word(a);
                    update_flags();
                end
                OP_STA: mem_store(a, cpu_acc);
                OP_ADD:
                begin
                    cpu_acc = sm_word(sm_value(cpu_acc) + sm_value(mem_word(a)));
                    update_flags();
                end
                OP_SUB:
                begin
                    cpu_acc = sm_word(sm_value(cpu_acc) - sm_value(mem_word(a)));
                    update_flags();
                end
                OP_JMP: cpu_pc = a;
                OP_CAL:
                    if (cpu_sp + 9'd2 > 9'd256 || cpu_sp > 9'd254)
                    begin
                        cpu_halt = 1'b1;
                        r.ev = EV_STACK;
                    end
                    else
                    begin
                        mem_store({3'b000, cpu_sp}, {4'h0, cpu_pc});
                        cpu_sp = cpu_sp + 9'd2;
                        cpu_pc = a;
                    end
                OP_MUL:
                begin
                    cpu_acc = sm_word(sm_value(cpu_acc) * sm_value(mem_word(a)));
                    update_flags();
                end
                OP_SYS:
                    if (a == SYS_RET)
                    begin
                        if (cpu_sp < 9'd2)
                        begin
                            cpu_halt = 1'b1;
                            r.ev = EV_STACK;
                        end
                        else
                        begin
                            cpu_sp = cpu_sp - 9'd2;
                            cpu_pc = 12'(mem_word({3'b000, cpu_sp}));
                        end
                    end
                    else if (a == SYS_IAC)
                        cpu_acc = sm_word(sm_value(cpu_acc) + 1);
                    else
                    begin
                        cpu_halt = 1'b1;
                        r.ev = EV_HALT;
                    end
                OP_BRZ: if (cpu_zero) cpu_pc = a;
                OP_BRN: if (cpu_neg) cpu_pc = a;
                OP_PRT:
                begin
                    r.ev = EV_NUM;
                    pv = sm_value(mem_word(a));
                    r.pv = pv[15:0];
                end
                OP_PRC:
                begin
                    r.ev = EV_CHAR;
                    r.pv = {8'h00, a[7:0]};
                end
                default: ;
            endcase
        end
        r.pc = cpu_pc;
        r.acc = cpu_acc;
        r.hlt = cpu_halt;
        return r;
    endfunction

    function automatic logic [15:0] boot_word(logic [11:0] a);
        case (a)
            12'h100: return 16'h8005;
            12'h102: return 16'h1200;
            12'h104: return 16'h3200;
            12'h106: return 16'h4204;
            12'h108: return 16'h7204;
            12'h10A: return 16'h8002;
            12'h10C: return 16'h2206;
            12'h10E: return 16'h1202;
            12'h110: return 16'h9000;
            12'h112: return 16'hA000;
            12'h114: return 16'h1208;
            12'h116: return 16'h911A;
            12'h118: return 16'h0000;
            12'h11A: return 16'h1204;
            12'h11C: return 16'hA120;
            12'h11E: return 16'h0000;
            12'h120: return 16'hB204;
            12'h122: return 16'hC0FF;
            12'h124: return 16'h6130;
            12'h126: return 16'hD000;
            12'h128: return 16'h8FFF;
            12'h130: return 16'h8005;
            12'h200: return 16'h7FFF;
            12'h202: return 16'h8000;
            12'h204: return 16'hFFFF;
            12'h208: return 16'h0000;
            12'h400: return 16'h6400;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(logic [1:0] f, logic [11:0] a, logic [15:0] d,
                             bit typed, step_res_t want);
        step_res_t r;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        func = f;
        address = a;
        data = d;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        r = cpu_step(f, a, d);
        pending_res.push_back(typed ? want : r);
        beats_in++;
        @(negedge clk);
    endtask

    task automatic write_start(logic [11:0] v);
        in_valid = 1'b0;
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = '0;
        pwdata = {20'h0, v};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cpu_start = v;
    endtask

    function automatic void add_row(row_kind_t k, logic [1:0] f, logic [11:0] a,
                                    logic [15:0] d, bit typed, step_res_t want);
        stim_row_t row;
        row.kind = k;
        row.func = f;
        row.addr = a;
        row.data = d;
        row.typed = typed;
        row.want = want;
        rows.push_back(row);
    endfunction

    always @(negedge clk)
    begin
        if (!idle_on)
            out_stall = 1'b0;
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall = 1'b0;
            if ($urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 7);
        end
    end

    always @(posedge clk)
    begin
        step_res_t e;
        step_res_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{event_res, print_value, program_counter, accumulator, halted};
            beats_out++;
            if (event_res == EV_NUM || event_res == EV_CHAR)
                n_prints++;
            if (event_res == EV_HALT || event_res == EV_STACK)
                n_halts++;
            if (pending_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
            end
            else
            begin
                e = pending_res.pop_front();
                if (got !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %p, actual %p", beats_out, e, got);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        step_res_t none;
        step_res_t w;
        logic [1:0] f;
        logic [11:0] a;
        logic [15:0] d;
        logic [11:0] starts [4];
        int k;
        none = '0;
        foreach (cpu_mem[i])
            cpu_mem[i] = 8'h00;
        cpu_pc = '0;
        cpu_acc = '0;
        cpu_neg = 1'b0;
        cpu_zero = 1'b0;
        cpu_sp = '0;
        cpu_halt = 1'b0;
        cpu_start = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 12'h220; i += 2)
            send_beat(FUNC_WRITE, 12'(i), boot_word(12'(i)), 1'b0, none);
        send_beat(FUNC_WRITE, 12'h400, boot_word(12'h400), 1'b0, none);

        add_row(ROW_CFG, FUNC_WRITE, 12'h100, 16'h0, 1'b0, none);
        add_row(ROW_BEAT, FUNC_RESTART, 12'h0, 16'h0, 1'b0, none);
        add_row(ROW_BEAT, FUNC_EXEC, 12'h0, 16'h0, 1'b1,
                '{EV_STACK, 16'h0, 12'h102, 16'h0, 1'b1});
        add_row(ROW_BEAT, FUNC_EXEC, 12'hFFF, 16'hFFFF, 1'b1,
                '{EV_NONE, 16'h0, 12'h102, 16'h0, 1'b1});
        add_row(ROW_CFG, FUNC_WRITE, 12'h102, 16'h0, 1'b0, none);
        add_row(ROW_BEAT, FUNC_RESTART, 12'h0, 16'h0, 1'b0, none);
        for (int i = 0; i < 14; i++)
            add_row(ROW_BEAT, FUNC_EXEC, 12'h0, 16'h0, 1'b0, none);
        add_row(ROW_BEAT, FUNC_EXEC, 12'h0, 16'h0, 1'b1,
                '{EV_CHAR, 16'h00FF, 12'h124, 16'hFFFF, 1'b0});
        for (int i = 0; i < 3; i++)
            add_row(ROW_BEAT, FUNC_EXEC, 12'h0, 16'h0, 1'b0, none);
        add_row(ROW_BEAT, FUNC_EXEC, 12'h0, 16'h0, 1'b1,
                '{EV_HALT, 16'h0, 12'h12A, 16'hFFFF, 1'b1});
        add_row(ROW_BEAT, 2'd3, 12'hFFF, 16'hFFFF, 1'b0, none);
        add_row(ROW_BEAT, FUNC_WRITE, 12'hFFF, 16'hABCD, 1'b0, none);

        foreach (rows[i])
            if (rows[i].kind == ROW_CFG)
                write_start(rows[i].addr);
            else
                send_beat(rows[i].func, rows[i].addr, rows[i].data, rows[i].typed,
                          rows[i].want);

        write_start(12'h400);
        send_beat(FUNC_RESTART, 12'h0, 16'h0, 1'b0, none);
        for (int i = 0; i < 130; i++)
            send_beat(FUNC_EXEC, 12'h0, 16'h0, 1'b0, none);

        starts[0] = 12'h000;
        starts[1] = 12'hFFF;
        starts[2] = 12'($urandom);
        starts[3] = 12'h100;
        for (int p = 0; p < 4; p++)
        begin
            write_start(starts[p]);
            if (p == 3)
                idle_on = 1'b0;
            for (int i = 0; i < 390; i++)
            begin
                k = $urandom_range(0, 99);
                a = 12'($urandom);
                d = 16'($urandom);
                if (cpu_halt && $urandom_range(0, 1) == 0)
                    f = FUNC_RESTART;
                else if (k < 60)
                    f = FUNC_EXEC;
                else if (k < 86)
                    f = FUNC_WRITE;
                else if (k < 97)
                    f = FUNC_RESTART;
                else
                    f = 2'd3;
                send_beat(f, a, d, 1'b0, none);
            end
        end

        in_valid = 1'b0;
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("%0d beats sent, %0d results checked, %0d prints, %0d halts",
                 beats_in, beats_out, n_prints, n_halts);
        $display("start addresses used: 0x100 0x102 0x400 0x000 0xFFF 0x%03h", starts[2]);
        if (mismatches == 0 && pending_res.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
